// ===== rtl/core/bsev_pkg.sv =====
// Shared types and constants of the B-spline evaluator.
// No dependencies; used by bsev_muldiv and bspline_evaluator.
package bsev_pkg;

  localparam int unsigned MAX_KNOTS_DEF  = 32;
  localparam int unsigned MAX_DEGREE_DEF = 4;

  localparam int unsigned DATA_W  = 32;  // Q16.16 knots, coefficients, x
  localparam int unsigned BASIS_W = 32;  // unsigned Q2.30 basis values
  localparam int unsigned DIFF_W  = 33;  // difference of two Q16.16 values
  localparam int unsigned PROD_W  = BASIS_W + DIFF_W;
  localparam int unsigned QUOT_W  = 41;  // quotient capped at 2^40
  localparam int unsigned TERM_W  = QUOT_W + 1;
  localparam int unsigned ACC_W   = 70;

  localparam logic [BASIS_W-1:0] ONE_Q30    = BASIS_W'(1) << 30;
  localparam logic [QUOT_W-1:0]  TERM_CAP   = QUOT_W'(1) << 40;
  localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(1) << 29;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_WRITE_KNOT = 2'd0;
  localparam logic [1:0] OP_WRITE_COEF = 2'd1;
  localparam logic [1:0] OP_EVALUATE   = 2'd2;

  // Status codes of a result transaction.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OUTSIDE   = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEGREE     = 2'd0;
  localparam logic [1:0] CFG_COEF_COUNT = 2'd1;

  typedef struct packed {
    logic start;
    logic mul_only;
  } mdu_ctrl_t;

endpackage

// ===== rtl/core/bsev_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bsev_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bsev_muldiv.sv =====
// Shared multiply / restoring-divide unit: min(floor(a*n/d), 2^40), or a*n alone.
// Depends on bsev_pkg.
module bsev_muldiv (
  input  logic                             clk,
  input  logic                             rst,
  input  bsev_pkg::mdu_ctrl_t              ctrl,
  input  logic [bsev_pkg::BASIS_W-1:0]     a,
  input  logic [bsev_pkg::DIFF_W-1:0]      n,
  input  logic [bsev_pkg::DIFF_W-1:0]      d,
  output logic                             done,
  output logic [bsev_pkg::PROD_W-1:0]      product,
  output logic [bsev_pkg::QUOT_W-1:0]      quotient
);

  logic                          busy;
  logic [6:0]                    cnt;
  logic [bsev_pkg::DIFF_W-1:0]   divisor;
  logic [bsev_pkg::DIFF_W-1:0]   rem;
  logic [bsev_pkg::QUOT_W-1:0]   q;
  logic                          sat;
  logic [bsev_pkg::DIFF_W:0]     trial;
  logic                          ge;

  // One quotient bit per cycle, product bits taken from the top.
  assign trial = {rem, product[bsev_pkg::PROD_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  assign quotient = (sat || q > bsev_pkg::TERM_CAP) ? bsev_pkg::TERM_CAP : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      // A multiply alone finishes at once; a division finishes on its last quotient bit.
      done <= (ctrl.start && ctrl.mul_only) || (!ctrl.start && busy && (cnt == 7'd0));
      if (ctrl.start) begin
        product <= a * n;
        divisor <= d;
        rem     <= '0;
        q       <= '0;
        sat     <= 1'b0;
        cnt     <= 7'(bsev_pkg::PROD_W - 1);
        busy    <= !ctrl.mul_only;
      end else if (busy) begin
        rem     <= ge ? bsev_pkg::DIFF_W'(trial - {1'b0, divisor})
                      : bsev_pkg::DIFF_W'(trial);
        product <= product << 1;
        q       <= {q[bsev_pkg::QUOT_W-2:0], ge};
        if (ge && cnt >= 7'(bsev_pkg::QUOT_W)) begin
          sat <= 1'b1;
        end
        if (cnt == 7'd0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 7'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/bspline_evaluator.sv =====
// B-spline evaluator top level: sequencer, knot/coefficient/basis RAMs, shared divide unit.
// Depends on bsev_pkg, bsev_ram and bsev_muldiv.
// A table write answers in the cycle after it is accepted. An evaluation answers after its
//   recursion, sum and interval check, once the output register is free.
// One transaction at a time: a new one is taken only while idle.
// Reset (rst, synchronous): degree 0, coefficient_count 1, idle, no result pending.
module bspline_evaluator #(
  parameter int unsigned MAX_KNOTS  = bsev_pkg::MAX_KNOTS_DEF,
  parameter int unsigned MAX_DEGREE = bsev_pkg::MAX_DEGREE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         operation,
  input  logic [4:0]         table_index,
  input  logic signed [31:0] data_value,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] spline_value,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data
);

  localparam int unsigned AW    = $clog2(MAX_KNOTS);
  localparam int unsigned CNT_A = MAX_DEGREE + 33;
  localparam int unsigned CNT_B = MAX_KNOTS + 1;
  localparam int unsigned CW    = $clog2((CNT_A > CNT_B) ? CNT_A : CNT_B);
  localparam int unsigned ACC_W = bsev_pkg::ACC_W;

  // Sequencer states, one-hot.
  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_INIT_RD   = 13'b0000000000010,
    S_REC_NEXT  = 13'b0000000000100,
    S_REC_RD    = 13'b0000000001000,
    S_T1        = 13'b0000000010000,
    S_T1_WAIT   = 13'b0000000100000,
    S_T2        = 13'b0000001000000,
    S_T2_WAIT   = 13'b0000010000000,
    S_REC_WR    = 13'b0000100000000,
    S_SUM_RD    = 13'b0001000000000,
    S_SUM_WAIT  = 13'b0010000000000,
    S_STAT_RD   = 13'b0100000000000,
    S_DONE      = 13'b1000000000000
  } state_t;

  function automatic logic [32:0] abs33(input logic [32:0] v);
    abs33 = v[32] ? (~v + 33'd1) : v;
  endfunction

  state_t state;

  // Configuration registers, always taken; the user must make writes arrive only while idle.
  logic [2:0] degree;
  logic [4:0] coef_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree     <= 3'd0;
      coef_count <= 5'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bsev_pkg::CFG_DEGREE:     degree     <= cfg_data[2:0];
        bsev_pkg::CFG_COEF_COUNT: coef_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Decode of the incoming transaction against the current configuration.
  logic [CW-1:0] k_eff, nc_in, nk_in, idx_ext;
  logic          knot_bad, coef_bad, eval_bad;

  assign k_eff    = (CW'(degree) > CW'(MAX_DEGREE)) ? CW'(MAX_DEGREE) : CW'(degree);
  assign nc_in    = CW'(coef_count);
  assign nk_in    = k_eff + nc_in + CW'(1);
  assign idx_ext  = CW'(table_index);
  assign knot_bad = (idx_ext >= nk_in) || (idx_ext >= CW'(MAX_KNOTS));
  assign coef_bad = (idx_ext >= nc_in) || (idx_ext >= CW'(MAX_KNOTS));
  assign eval_bad = nk_in > CW'(MAX_KNOTS);

  // The output register frees the input side: a new transaction is taken while idle
  // unless a finished result is still being held back by the consumer.
  logic out_free, accept, eval_start;
  assign out_free   = !result_valid || !result_stall;
  assign item_stall = !((state == S_IDLE) && out_free);
  assign accept     = item_valid && !item_stall;
  assign eval_start = accept && (operation == bsev_pkg::OP_EVALUATE) && !eval_bad;

  // Sequencer working registers.
  logic [CW-1:0]        k_r, nc_r, n_r, i, d;
  logic [2:0]           step;
  logic signed [31:0]   x_r, ta, tb, tc, td;
  logic [31:0]          b0, b1;
  logic                 neg_r;
  logic signed [bsev_pkg::TERM_W-1:0] term1, term2;
  logic signed [ACC_W-1:0] acc;
  logic [1:0]           stat_r;

  // RAMs.
  logic [31:0]   knot_q, coef_q, basis_q;
  logic [CW-1:0] knot_ptr, basis_ptr;
  logic          knot_we, coef_we, basis_we;
  logic [31:0]   basis_wdata;

  assign knot_we = accept && (operation == bsev_pkg::OP_WRITE_KNOT) && !knot_bad;
  assign coef_we = accept && (operation == bsev_pkg::OP_WRITE_COEF) && !coef_bad;

  always_comb begin
    knot_ptr = i;
    unique case (state)
      S_INIT_RD: knot_ptr = (step == 3'd0) ? i : i + CW'(1);
      S_REC_RD: begin
        case (step)
          3'd0:    knot_ptr = i;
          3'd1:    knot_ptr = i + d;
          3'd2:    knot_ptr = i + CW'(1);
          3'd3:    knot_ptr = i + d + CW'(1);
          default: knot_ptr = i;
        endcase
      end
      S_STAT_RD: knot_ptr = (step == 3'd0) ? k_r : nc_r;
      default:   knot_ptr = i;
    endcase
  end

  assign basis_ptr = ((state == S_REC_RD) && (step != 3'd0)) ? i + CW'(1) : i;

  bsev_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knot_ram (
    .clk   (clk),
    .we    (knot_we),
    .waddr (AW'(table_index)),
    .wdata (data_value),
    .raddr (knot_ptr[AW-1:0]),
    .rdata (knot_q)
  );

  bsev_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (AW'(table_index)),
    .wdata (data_value),
    .raddr (i[AW-1:0]),
    .rdata (coef_q)
  );

  bsev_ram #(.WIDTH(bsev_pkg::BASIS_W), .DEPTH(MAX_KNOTS)) u_basis_ram (
    .clk   (clk),
    .we    (basis_we),
    .waddr (i[AW-1:0]),
    .wdata (basis_wdata),
    .raddr (basis_ptr[AW-1:0]),
    .rdata (basis_q)
  );

  // Recursion term operands. The left term weighs B[i] by (x - t[i]) / (t[i+d] - t[i]),
  // the right term weighs B[i+1] by (t[i+d+1] - x) / (t[i+d+1] - t[i+1]).
  logic signed [32:0] num1, den1, num2, den2;
  logic               skip1, skip2;

  assign num1  = {x_r[31], x_r} - {ta[31], ta};
  assign den1  = {tb[31], tb} - {ta[31], ta};
  assign num2  = {td[31], td} - {x_r[31], x_r};
  assign den2  = {td[31], td} - {tc[31], tc};
  // A zero knot span or a zero basis value makes the term zero without a division.
  assign skip1 = (den1 == 33'sd0) || (b0 == 32'd0);
  assign skip2 = (den2 == 33'sd0) || (b1 == 32'd0);

  // Shared multiply / divide unit.
  bsev_pkg::mdu_ctrl_t             mdu_ctrl;
  logic [bsev_pkg::BASIS_W-1:0]    mdu_a;
  logic [bsev_pkg::DIFF_W-1:0]     mdu_n, mdu_d;
  logic                            mdu_done;
  logic [bsev_pkg::PROD_W-1:0]     mdu_prod;
  logic [bsev_pkg::QUOT_W-1:0]     mdu_quot;

  always_comb begin
    mdu_ctrl.start    = 1'b0;
    mdu_ctrl.mul_only = 1'b0;
    mdu_a             = b0;
    mdu_n             = abs33(num1);
    mdu_d             = abs33(den1);
    if (state == S_T1) begin
      mdu_ctrl.start = !skip1;
    end else if (state == S_T2) begin
      mdu_ctrl.start = !skip2;
      mdu_a          = b1;
      mdu_n          = abs33(num2);
      mdu_d          = abs33(den2);
    end else if (state == S_SUM_RD) begin
      // Coefficient times basis: magnitude product, sign applied when accumulating.
      mdu_ctrl.start    = (step == 3'd1);
      mdu_ctrl.mul_only = 1'b1;
      mdu_a             = basis_q;
      mdu_n             = abs33({coef_q[31], coef_q});
    end
  end

  bsev_muldiv u_muldiv (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mdu_ctrl),
    .a        (mdu_a),
    .n        (mdu_n),
    .d        (mdu_d),
    .done     (mdu_done),
    .product  (mdu_prod),
    .quotient (mdu_quot)
  );

  // Sum of the two terms, clamped into the unsigned basis range.
  logic signed [bsev_pkg::TERM_W:0] term_sum;
  logic [31:0]                      term_clamped;
  logic signed [bsev_pkg::TERM_W-1:0] quot_signed;

  assign term_sum     = {term1[bsev_pkg::TERM_W-1], term1} + {term2[bsev_pkg::TERM_W-1], term2};
  assign term_clamped = term_sum[bsev_pkg::TERM_W] ? 32'd0 :
                        (|term_sum[bsev_pkg::TERM_W-1:32]) ? 32'hFFFF_FFFF : term_sum[31:0];
  assign quot_signed  = neg_r ? -$signed({1'b0, mdu_quot}) : $signed({1'b0, mdu_quot});

  // Degree-zero basis: half-open interval test [t[i], t[i+1]).
  logic init_hit;
  assign init_hit = (ta <= x_r) && (x_r < $signed(knot_q));

  assign basis_we    = ((state == S_INIT_RD) && (step == 3'd2)) || (state == S_REC_WR);
  assign basis_wdata = (state == S_INIT_RD) ? (init_hit ? bsev_pkg::ONE_Q30 : 32'd0)
                                            : term_clamped;

  // Accumulation of coefficient times basis in Q24.46.
  logic signed [ACC_W-1:0] prod_ext;
  assign prod_ext = {{(ACC_W - bsev_pkg::PROD_W){1'b0}}, mdu_prod};

  // Round to nearest (ties up) into Q16.16, then saturate to 32 bits.
  logic signed [ACC_W-1:0] rnd;
  logic                    sat_hi, sat_lo;
  logic signed [31:0]      final_value;

  assign rnd         = acc + $signed(bsev_pkg::ROUND_HALF);
  assign sat_hi      = !rnd[ACC_W-1] && (|rnd[ACC_W-2:61]);
  assign sat_lo      = rnd[ACC_W-1] && !(&rnd[ACC_W-2:61]);
  assign final_value = sat_hi ? 32'sh7FFF_FFFF : sat_lo ? 32'sh8000_0000 : $signed(rnd[61:30]);

  // The output register is loaded when a transaction other than a valid evaluation is
  // taken, which answers at once with value 0, or when an evaluation finishes.
  logic       result_load;
  logic [1:0] status_next;

  assign result_load = (accept && !eval_start) || ((state == S_DONE) && out_free);

  always_comb begin
    status_next = bsev_pkg::ST_OK;
    if (state == S_DONE) begin
      status_next = stat_r;
    end else begin
      case (operation)
        bsev_pkg::OP_WRITE_KNOT: status_next = knot_bad ? bsev_pkg::ST_BAD_INDEX
                                                        : bsev_pkg::ST_OK;
        bsev_pkg::OP_WRITE_COEF: status_next = coef_bad ? bsev_pkg::ST_BAD_INDEX
                                                        : bsev_pkg::ST_OK;
        bsev_pkg::OP_EVALUATE:   status_next = eval_bad ? bsev_pkg::ST_BAD_INDEX
                                                        : bsev_pkg::ST_OK;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      spline_value <= (state == S_DONE) ? final_value : 32'sd0;
      status       <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (eval_start) begin
            x_r  <= data_value;
            k_r  <= k_eff;
            nc_r <= nc_in;
            n_r  <= k_eff + nc_in;
            i    <= '0;
            d    <= CW'(1);
            step <= 3'd0;
            state <= ((k_eff + nc_in) == '0) ? S_REC_NEXT : S_INIT_RD;
          end
        end

        S_INIT_RD: begin
          case (step)
            3'd0: step <= 3'd1;
            3'd1: begin
              ta   <= $signed(knot_q);
              step <= 3'd2;
            end
            default: begin
              step <= 3'd0;
              if (i + CW'(1) < n_r) begin
                i <= i + CW'(1);
              end else begin
                i     <= '0;
                d     <= CW'(1);
                state <= S_REC_NEXT;
              end
            end
          endcase
        end

        S_REC_NEXT: begin
          step <= 3'd0;
          if (d > k_r) begin
            acc   <= '0;
            i     <= '0;
            state <= (nc_r == '0) ? S_STAT_RD : S_SUM_RD;
          end else if (i + d < n_r) begin
            state <= S_REC_RD;
          end else begin
            d <= d + CW'(1);
            i <= '0;
          end
        end

        S_REC_RD: begin
          case (step)
            3'd0: step <= 3'd1;
            3'd1: begin
              ta   <= $signed(knot_q);
              b0   <= basis_q;
              step <= 3'd2;
            end
            3'd2: begin
              tb   <= $signed(knot_q);
              b1   <= basis_q;
              step <= 3'd3;
            end
            3'd3: begin
              tc   <= $signed(knot_q);
              step <= 3'd4;
            end
            default: begin
              td    <= $signed(knot_q);
              step  <= 3'd0;
              state <= S_T1;
            end
          endcase
        end

        S_T1: begin
          if (skip1) begin
            term1 <= '0;
            state <= S_T2;
          end else begin
            neg_r <= num1[32] ^ den1[32];
            state <= S_T1_WAIT;
          end
        end

        S_T1_WAIT: begin
          if (mdu_done) begin
            term1 <= quot_signed;
            state <= S_T2;
          end
        end

        S_T2: begin
          if (skip2) begin
            term2 <= '0;
            state <= S_REC_WR;
          end else begin
            neg_r <= num2[32] ^ den2[32];
            state <= S_T2_WAIT;
          end
        end

        S_T2_WAIT: begin
          if (mdu_done) begin
            term2 <= quot_signed;
            state <= S_REC_WR;
          end
        end

        S_REC_WR: begin
          i     <= i + CW'(1);
          state <= S_REC_NEXT;
        end

        S_SUM_RD: begin
          if (step == 3'd0) begin
            step <= 3'd1;
          end else begin
            neg_r <= coef_q[31];
            step  <= 3'd0;
            state <= S_SUM_WAIT;
          end
        end

        S_SUM_WAIT: begin
          if (mdu_done) begin
            acc <= neg_r ? acc - prod_ext : acc + prod_ext;
            if (i + CW'(1) < nc_r) begin
              i     <= i + CW'(1);
              state <= S_SUM_RD;
            end else begin
              state <= S_STAT_RD;
            end
          end
        end

        S_STAT_RD: begin
          // Base interval check: x against t[degree] and t[coefficient_count].
          case (step)
            3'd0: step <= 3'd1;
            3'd1: begin
              ta   <= $signed(knot_q);
              step <= 3'd2;
            end
            default: begin
              stat_r <= ((x_r < ta) || (x_r > $signed(knot_q))) ? bsev_pkg::ST_OUTSIDE
                                                                 : bsev_pkg::ST_OK;
              step   <= 3'd0;
              state  <= S_DONE;
            end
          endcase
        end

        S_DONE: begin
          // The result is loaded into the output register as soon as it is free.
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
